// File: hw/rtl/idr_pkg.sv
// idr_pkg: shared widths, codes, reset values and structs of the id allocator
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package idr_pkg;

  localparam int POOL_DEPTH_DEF = 1024;
  localparam int ID_W           = 32;
  localparam int USE_W          = 11;
  localparam int ST_W           = 2;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [ID_W-1:0] START_RST = 32'd1;
  localparam logic [ID_W-1:0] END_RST   = 32'd65535;
  localparam logic [ID_W-1:0] THR_RST   = 32'd1024;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_PUT_EMPTY = 2'd2;

  localparam logic [1:0] REG_START_ID = 2'd0;
  localparam logic [1:0] REG_END_ID   = 2'd1;
  localparam logic [1:0] REG_REUSE    = 2'd2;

  typedef struct packed {
    logic            load_fresh;
    logic [ID_W-1:0] start_id;
    logic [ID_W-1:0] end_id;
    logic [ID_W-1:0] reuse_threshold;
  } cfg_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] data;
  } fifo_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/idr_if.sv
// idr_in_if / idr_out_if: valid-ready channels of the id allocator
// depends on idr_pkg
`default_nettype none

interface idr_in_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [idr_pkg::ID_W-1:0] returned_id;

  modport source (output valid, output operation, output returned_id, input ready);
  modport sink   (input valid, input operation, input returned_id, output ready);
endinterface

interface idr_out_if;
  logic                      valid;
  logic                      ready;
  logic [idr_pkg::ID_W-1:0]  granted_id;
  logic [idr_pkg::ST_W-1:0]  status;
  logic [idr_pkg::USE_W-1:0] in_use_count;

  modport source (output valid, output granted_id, output status, output in_use_count,
                  input ready);
  modport sink   (input valid, input granted_id, input status, input in_use_count,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/idr_cfg_regs.sv
// idr_cfg_regs: apb register file (start_id, end_id, reuse_threshold)
// depends on idr_pkg
`default_nettype none

module idr_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [idr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [idr_pkg::DATA_W-1:0]   pwdata,
  output logic      [idr_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output idr_pkg::cfg_t                     cfg
);

  logic [idr_pkg::ID_W-1:0] start_r, end_r, thr_r;
  logic                     load_start;
  logic                     wr;
  logic [1:0]               idx;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite;
  assign idx        = paddr[3:2];
  assign load_start = wr && (idx == idr_pkg::REG_START_ID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= idr_pkg::START_RST;
      end_r   <= idr_pkg::END_RST;
      thr_r   <= idr_pkg::THR_RST;
    end else begin
      if (wr) begin
        unique case (idx)
          idr_pkg::REG_START_ID: start_r <= pwdata;
          idr_pkg::REG_END_ID:   end_r   <= pwdata;
          idr_pkg::REG_REUSE:    thr_r   <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      idr_pkg::REG_START_ID: prdata = start_r;
      idr_pkg::REG_END_ID:   prdata = end_r;
      idr_pkg::REG_REUSE:    prdata = thr_r;
      default:               prdata = '0;
    endcase
  end

  // fresh counter loads in the same edge as the register write
  assign cfg.load_fresh      = load_start;
  assign cfg.start_id        = load_start ? pwdata : start_r;
  assign cfg.end_id          = end_r;
  assign cfg.reuse_threshold = thr_r;

endmodule

`default_nettype wire

// File: hw/rtl/idr_free_fifo.sv
// idr_free_fifo: free-id queue in a synchronous memory, head/tail pointers and fill count
// depends on idr_pkg
`default_nettype none

module idr_free_fifo #(
  parameter int POOL_DEPTH = idr_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire idr_pkg::fifo_req_t         req,
  output logic                            empty,
  output logic [idr_pkg::ID_W-1:0]        pop_data
);

  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(POOL_DEPTH - 1);

  logic [idr_pkg::ID_W-1:0] mem [POOL_DEPTH];
  logic [idr_pkg::ID_W-1:0] rd_r;
  logic [PW-1:0]            head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]            count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (req.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
    if (req.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.data;
    end
    if (req.pop) begin
      rd_r <= mem[head_r];
    end
  end

  assign empty    = (count_r == '0);
  assign pop_data = rd_r;

endmodule

`default_nettype wire

// File: hw/rtl/idr_ctrl.sv
// idr_ctrl: request decode, fresh counter, in-use and node counts, result register
// depends on idr_pkg and idr_if
`default_nettype none

module idr_ctrl #(
  parameter int POOL_DEPTH = idr_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  idr_in_if.sink                    in_ch,
  idr_out_if.source                 out_ch,
  input  wire idr_pkg::cfg_t        cfg,
  input  wire logic                 fifo_empty,
  input  wire logic [idr_pkg::ID_W-1:0] pop_data,
  output idr_pkg::fifo_req_t        fifo_req
);

  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] POOL_MAX = CW'(POOL_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [idr_pkg::ID_W-1:0]  fresh_r, fresh_nxt;
  logic [CW-1:0]             held_r, held_nxt, nodes_r, nodes_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [idr_pkg::ID_W-1:0]  granted_r, granted_nxt;
  logic [idr_pkg::ST_W-1:0]  status_r, status_nxt;
  logic [idr_pkg::USE_W-1:0] in_use_r, in_use_nxt;

  logic accept, is_get, use_fresh, fresh_ok, grant_fresh, do_pop, do_push;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_get      = (in_ch.operation == idr_pkg::OP_GET);
  assign use_fresh   = (fresh_r < cfg.reuse_threshold) || fifo_empty;
  assign fresh_ok    = (fresh_r < cfg.end_id) && (nodes_r < POOL_MAX);
  assign grant_fresh = accept && is_get && use_fresh && fresh_ok;
  assign do_pop      = accept && is_get && !use_fresh;
  assign do_push     = accept && !is_get && (held_r != '0);

  assign fifo_req.push = do_push;
  assign fifo_req.pop  = do_pop;
  assign fifo_req.data = in_ch.returned_id;

  always_comb begin
    state_nxt     = state_r;
    fresh_nxt     = fresh_r;
    held_nxt      = held_r;
    nodes_nxt     = nodes_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    in_use_nxt    = in_use_r;

    if (cfg.load_fresh) begin
      fresh_nxt = cfg.start_id;
    end else if (grant_fresh) begin
      fresh_nxt = fresh_r + 1'b1;
    end
    if (grant_fresh) begin
      nodes_nxt = nodes_r + 1'b1;
    end
    if (grant_fresh || do_pop) begin
      held_nxt = held_r + 1'b1;
    end else if (do_push) begin
      held_nxt = held_r - 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_use_nxt = idr_pkg::USE_W'(held_nxt);
          if (do_pop) begin
            status_nxt = idr_pkg::ST_OK;
            state_nxt  = S_POP;
          end else begin
            out_valid_nxt = 1'b1;
            if (is_get) begin
              granted_nxt = grant_fresh ? fresh_r : cfg.end_id;
              status_nxt  = grant_fresh ? idr_pkg::ST_OK : idr_pkg::ST_EXHAUSTED;
            end else begin
              granted_nxt = '0;
              status_nxt  = (held_r != '0) ? idr_pkg::ST_OK : idr_pkg::ST_PUT_EMPTY;
            end
          end
        end
      end
      S_POP: begin
        granted_nxt   = pop_data;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= idr_pkg::START_RST;
      held_r      <= '0;
      nodes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      held_r      <= held_nxt;
      nodes_r     <= nodes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
    in_use_r  <= in_use_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_id   = granted_r;
  assign out_ch.status       = status_r;
  assign out_ch.in_use_count = in_use_r;

endmodule

`default_nettype wire

// File: hw/rtl/id_allocator_with_recycling_unit.sv
// id_allocator_with_recycling_unit: top level of the id allocator with free-id recycling
// depends on idr_pkg, idr_if, idr_cfg_regs, idr_free_fifo, idr_ctrl
//
//   channel  direction  handshake       payload
//   in_ch    in         valid/ready     operation, returned_id
//   out_ch   out        valid/ready     granted_id, status, in_use_count
//   cfg_*    in         apb write/read  start_id, end_id, reuse_threshold
//
// fresh grant, failed get and put: 1 cycle per word, result registered at accept
// recycled grant: free-id read registered at accept, result loaded in the pop state
// synchronous active-low reset; the free-id memory is not cleared and needs no sweep
// a new word is taken in idle while the result register is empty or being drained
`default_nettype none

module id_allocator_with_recycling_unit #(
  parameter int POOL_DEPTH = idr_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  idr_in_if.sink                          in_ch,
  idr_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [idr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [idr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [idr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  idr_pkg::cfg_t            cfg;
  idr_pkg::fifo_req_t       fifo_req;
  logic                     fifo_empty;
  logic [idr_pkg::ID_W-1:0] pop_data;

  idr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  idr_free_fifo #(.POOL_DEPTH(POOL_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (fifo_req),
    .empty    (fifo_empty),
    .pop_data (pop_data)
  );

  idr_ctrl #(.POOL_DEPTH(POOL_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg),
    .fifo_empty (fifo_empty),
    .pop_data   (pop_data),
    .fifo_req   (fifo_req)
  );

endmodule

`default_nettype wire

// File: dv/idr_alloc_checker.sv
// idr_alloc_checker: watches the request, result and register ports of the id allocator
// keeps its own allocator state, predicts every result word and compares it field by field
// depends on idr_pkg and idr_if
module idr_alloc_checker #(
  parameter int POOL_DEPTH = idr_pkg::POOL_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  idr_in_if                          in_ch,
  idr_out_if                         out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [idr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [idr_pkg::DATA_W-1:0] cfg_pwdata,
  output int                         pending_words,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import idr_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    logic [ST_W-1:0]  status;
    logic [USE_W-1:0] in_use_count;
  } grant_word_t;

  logic [ID_W-1:0] id_limit;
  logic [ID_W-1:0] reuse_thr;
  logic [ID_W-1:0] fresh_ctr;
  logic [ID_W-1:0] freed_ids[$];
  int              held_ids;
  int              nodes_made;
  grant_word_t     grants_due[$];
  int              mismatches;

  assign fail_count = mismatches;

  function automatic grant_word_t allocate(input logic op, input logic [ID_W-1:0] rid);
    grant_word_t w;
    w.granted_id = '0;
    w.status     = ST_OK;
    if (op == OP_GET) begin
      w.granted_id = id_limit;
      w.status     = ST_EXHAUSTED;
      if (fresh_ctr < reuse_thr || freed_ids.size() == 0) begin
        // fresh path fails on a full pool or a counter at the limit, freed ids or not
        if (fresh_ctr < id_limit && nodes_made < POOL_DEPTH) begin
          w.granted_id = fresh_ctr;
          w.status     = ST_OK;
          fresh_ctr++;
          nodes_made++;
          held_ids++;
        end
      end else begin
        w.granted_id = freed_ids.pop_front();
        w.status     = ST_OK;
        held_ids++;
      end
    end else if (held_ids == 0) begin
      w.status = ST_PUT_EMPTY;
    end else begin
      freed_ids.push_back(rid);
      held_ids--;
    end
    w.in_use_count = USE_W'(held_ids);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    grant_word_t want;
    if (!rst_n) begin
      id_limit   = END_RST;
      reuse_thr  = THR_RST;
      fresh_ctr  = START_RST;
      held_ids   = 0;
      nodes_made = 0;
      freed_ids.delete();
      grants_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_START_ID: fresh_ctr = cfg_pwdata[ID_W-1:0];
          REG_END_ID:   id_limit  = cfg_pwdata[ID_W-1:0];
          REG_REUSE:    reuse_thr = cfg_pwdata[ID_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result word: granted_id %0h status %0d in_use_count %0d",
                 out_ch.granted_id, out_ch.status, out_ch.in_use_count);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (out_ch.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0h, got %0h", want.granted_id, out_ch.granted_id);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.in_use_count !== want.in_use_count) begin
            $error("in_use_count: expected %0d, got %0d",
                   want.in_use_count, out_ch.in_use_count);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        grants_due.push_back(allocate(in_ch.operation, in_ch.returned_id));
    end
    pending_words <= grants_due.size();
  end

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

endmodule

// File: dv/id_allocator_with_recycling_unit_tb.sv
// id_allocator_with_recycling_unit_tb: drives requests, register writes and result back-pressure
// into the id allocator and gives the verdict from the count kept by idr_alloc_checker
// depends on idr_pkg, idr_if, idr_alloc_checker and the allocator rtl
module id_allocator_with_recycling_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idr_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int         LONG_STALL   = 300;
  localparam int         CYCLE_LIMIT  = 500000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  int                pending_words;
  int                fail_count;
  int                cycle_count = 0;
  logic              tx_steady = 1'b0;
  logic              rx_steady = 1'b0;
  logic              stall_req = 1'b0;
  logic              rx_hold   = 1'b0;

  idr_in_if  in_ch ();
  idr_out_if out_ch ();

  id_allocator_with_recycling_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  idr_alloc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .pending_words (pending_words),
    .fail_count    (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : rx_side
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (gap != 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        while (rx_hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // one long receiver hold-off so the block backs up into the request side
  initial begin : rx_stall
    wait (stall_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_word(input logic op, input logic [ID_W-1:0] rid);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.returned_id <= rid;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [ID_W-1:0] s_id, input logic [ID_W-1:0] e_id,
                           input logic [ID_W-1:0] thr);
    reg_write(REG_START_ID, s_id);
    reg_write(REG_END_ID, e_id);
    reg_write(REG_REUSE, thr);
  endtask

  task automatic run_phase(input int words, input int get_pct);
    logic [ID_W-1:0] rid;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(0, 3))
        0:       rid = '0;
        1:       rid = '1;
        default: rid = $urandom;
      endcase
      push_word(($urandom_range(0, 99) < get_pct) ? OP_GET : OP_PUT, rid);
    end
    settle();
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_GET;
    in_ch.returned_id = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: put on empty, fresh ids, fresh preferred below threshold
    push_word(OP_PUT, 32'hFFFF_FFFF);
    push_word(OP_GET, '0);
    push_word(OP_GET, '0);
    push_word(OP_GET, '0);
    push_word(OP_PUT, 32'hFFFF_FFFF);
    push_word(OP_PUT, 32'h0000_0000);
    push_word(OP_PUT, 32'h5A5A_5A5A);
    push_word(OP_PUT, 32'hA5A5_A5A5);
    push_word(OP_GET, '0);
    settle();

    // recycling from the oldest freed id, then fresh once the fifo is empty
    reg_write(REG_REUSE, '0);
    repeat (4) push_word(OP_GET, '0);
    settle();

    // counter at its limit, unmapped register write ignored
    configure(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    reg_write(REG_UNMAPPED, 32'h0000_0007);
    push_word(OP_GET, '0);
    push_word(OP_GET, '0);
    push_word(OP_PUT, 32'h1234_5678);
    push_word(OP_GET, '0);
    settle();
    configure('0, '0, 32'hFFFF_FFFF);
    push_word(OP_GET, '0);
    push_word(OP_PUT, '0);
    push_word(OP_GET, '0);
    settle();

    // mostly fresh gets with a long result stall as the phase begins
    configure(32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stall_req = 1'b1;
    run_phase(300, 95);

    // back-to-back traffic, mostly fresh gets
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    configure(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(300, 97);

    // put-heavy recycling with random limits
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    configure($urandom, $urandom, '0);
    run_phase(200, 20);

    rx_steady = 1'b1;
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    run_phase(80, 50);

    tx_steady = 1'b1;
    rx_steady = 1'b0;
    configure(32'h0000_0100, 32'h0000_0200, 32'h0000_0180);
    run_phase(50, 50);

    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
